// ===== sv/dassort_pkg.sv =====
// ----------------------------------------------------------------------------
// dassort_pkg
// Types, constants and microcode table of the degree assortativity block.
// ----------------------------------------------------------------------------
package dassort_pkg;

    localparam int MATRIX_SIZE = 64;

    localparam int IDX_W    = 6;
    localparam int WEIGHT_W = 24;
    localparam int COEF_W   = 27;
    localparam int STAT_W   = 2;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 32;

    localparam int CROSS_W  = 50;
    localparam int FIRST_W  = 42;
    localparam int SECOND_W = 48;
    localparam int HALF_W   = FIRST_W / 2;
    localparam int SQ_IDX_W = 2 * IDX_W;
    localparam int WI_W     = WEIGHT_W + IDX_W;
    localparam int WSQ_W    = WEIGHT_W + SQ_IDX_W;
    localparam int QFRAC    = 17;

    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(65536);
    localparam logic signed [COEF_W-1:0] COEF_ERR = COEF_W'(65536000);
    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_DEGEN = 2'd1,
        ST_DIV0  = 2'd2
    } status_t;

    typedef logic [3:0] step_t;

    localparam step_t STEP_ACCEPT = 4'd0;
    localparam step_t STEP_MUL1   = 4'd1;
    localparam step_t STEP_MUL2   = 4'd2;
    localparam step_t STEP_ACC    = 4'd3;
    localparam step_t STEP_SQ_LL  = 4'd4;
    localparam step_t STEP_SQ_HL  = 4'd5;
    localparam step_t STEP_SQ_MID = 4'd6;
    localparam step_t STEP_SQ_HH  = 4'd7;
    localparam step_t STEP_DIFF   = 4'd8;
    localparam step_t STEP_PREP   = 4'd9;
    localparam step_t STEP_DIV    = 4'd10;
    localparam step_t STEP_OUT    = 4'd11;

    typedef enum logic [3:0] {
        OP_NOP    = 4'd0,
        OP_ACCEPT = 4'd1,
        OP_MUL1   = 4'd2,
        OP_MUL2   = 4'd3,
        OP_ACC    = 4'd4,
        OP_SQ_LL  = 4'd5,
        OP_SQ_HL  = 4'd6,
        OP_SQ_MID = 4'd7,
        OP_SQ_HH  = 4'd8,
        OP_DIFF   = 4'd9,
        OP_PREP   = 4'd10,
        OP_DIV    = 4'd11,
        OP_OUT    = 4'd12
    } op_t;

    // wait conditions hold the step until clear, then go to target;
    // jump conditions go to target when true, else fall through
    typedef enum logic [2:0] {
        COND_NEXT     = 3'd0,
        COND_ALWAYS   = 3'd1,
        COND_WAIT_IN  = 3'd2,
        COND_WAIT_OUT = 3'd3,
        COND_NOT_LAST = 3'd4,
        COND_DEN_ZERO = 3'd5,
        COND_CNT_NZ   = 3'd6
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_t;

    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        case (s)
            STEP_ACCEPT: w = '{OP_ACCEPT, COND_WAIT_IN,  STEP_MUL1};
            STEP_MUL1:   w = '{OP_MUL1,   COND_NEXT,     STEP_ACCEPT};
            STEP_MUL2:   w = '{OP_MUL2,   COND_NEXT,     STEP_ACCEPT};
            STEP_ACC:    w = '{OP_ACC,    COND_NOT_LAST, STEP_ACCEPT};
            STEP_SQ_LL:  w = '{OP_SQ_LL,  COND_NEXT,     STEP_ACCEPT};
            STEP_SQ_HL:  w = '{OP_SQ_HL,  COND_NEXT,     STEP_ACCEPT};
            STEP_SQ_MID: w = '{OP_SQ_MID, COND_NEXT,     STEP_ACCEPT};
            STEP_SQ_HH:  w = '{OP_SQ_HH,  COND_NEXT,     STEP_ACCEPT};
            STEP_DIFF:   w = '{OP_DIFF,   COND_NEXT,     STEP_ACCEPT};
            STEP_PREP:   w = '{OP_PREP,   COND_DEN_ZERO, STEP_OUT};
            STEP_DIV:    w = '{OP_DIV,    COND_CNT_NZ,   STEP_DIV};
            STEP_OUT:    w = '{OP_OUT,    COND_WAIT_OUT, STEP_ACCEPT};
            default:     w = '{OP_NOP,    COND_ALWAYS,   STEP_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

// ===== sv/degree_assortativity.sv =====
// ----------------------------------------------------------------------------
// degree_assortativity
// Streams joint degree matrix entries, accumulates the cross sum and the
// marginal moments, and on the last entry returns the assortativity
// coefficient as signed Q10.16 with a status code.
// ----------------------------------------------------------------------------
// An ordinary entry runs accept, two multiply steps and accumulate, all
// driven by a 12-step microcode table. An entry marked last then runs the
// squaring steps, difference, prepare, divide and output, skipping divide
// when the denominator is zero; the quotient comes from a restoring divider
// that retires one bit per cycle over a 102-bit dividend (WEIGHT_FRAC_BITS
// up to 34). The result sits in an output register, so the next matrix
// streams in while it waits; a last entry that finds the previous result
// still unread holds at the output step until that word is taken.
module degree_assortativity
    import dassort_pkg::*;
#(
    parameter int WEIGHT_FRAC_BITS = 24
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // row_degree, col_degree, weight, zero pad
    input  logic             s_axis_tlast,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // coefficient, status, zero pad
    output logic             m_axis_tlast
);

    localparam int PW     = (2 * FIRST_W > CROSS_W + WEIGHT_FRAC_BITS) ?
                            2 * FIRST_W : CROSS_W + WEIGHT_FRAC_BITS;
    localparam int NB     = PW + QFRAC + 1;
    localparam int CNT_W  = $clog2(NB);

    ucode_t ctl;
    step_t  step_reg, step_next;

    logic [IDX_W-1:0]    row_reg, col_reg;
    logic [WEIGHT_W-1:0] w_reg;
    logic                last_reg;

    logic [SQ_IDX_W-1:0] ii_reg, ij_reg;
    logic [WI_W-1:0]     wi_reg;
    logic [WSQ_W-1:0]    wii_reg, wij_reg;

    logic [CROSS_W-1:0]  cross_reg;
    logic [FIRST_W-1:0]  first_reg;
    logic [SECOND_W-1:0] second_reg;

    logic [2*HALF_W-1:0] prod_reg;
    logic [PW-1:0]       sq_reg;
    logic [PW-1:0]       num_reg, den_reg;
    logic                nneg_reg, dneg_reg;

    logic [NB-1:0]       nsh_reg;
    logic [PW:0]         dd_reg;
    logic [PW:0]         rem_reg;
    logic [COEF_W-1:0]   q_reg;
    logic                ov_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic                out_valid_reg;
    logic [OUT_W-1:0]    out_data_reg;

    logic                hold, jump, out_busy, entry_ok, lower, diag;
    logic [FIRST_W:0]    first_sum;
    logic [SECOND_W:0]   second_sum;
    logic [CROSS_W:0]    cross_sum;
    logic [CROSS_W-1:0]  cross_add;
    logic [PW:0]         cw, sw, sqx, ndiff, ddiff;
    logic [PW+1:0]       rem_sh, rem_sub;
    logic                neg, qsat;
    logic [COEF_W-1:0]   coef;
    status_t             stat;
    logic [HALF_W-1:0]   f_lo, f_hi;

    assign ctl      = ucode_rom(step_reg);
    assign out_busy = out_valid_reg && !m_axis_tready;

    always_comb
    begin
        hold = 1'b0;
        jump = 1'b0;
        case (ctl.cond)
            COND_NEXT:     jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_WAIT_IN:  begin hold = !s_axis_tvalid; jump = 1'b1; end
            COND_WAIT_OUT: begin hold = out_busy; jump = 1'b1; end
            COND_NOT_LAST: jump = !last_reg;
            COND_DEN_ZERO: jump = (den_reg == '0);
            COND_CNT_NZ:   jump = (cnt_reg != '0);
            default:       jump = 1'b1;
        endcase
        if (hold)
            step_next = step_reg;
        else if (jump)
            step_next = ctl.target;
        else
            step_next = step_reg + step_t'(1);
    end

    assign s_axis_tready = (ctl.op == OP_ACCEPT);

    // accumulate datapath
    always_comb
    begin
        entry_ok = (row_reg != '0) && (col_reg != '0) &&
                   (32'(row_reg) < MATRIX_SIZE) && (32'(col_reg) < MATRIX_SIZE);
        lower    = col_reg < row_reg;
        diag     = col_reg == row_reg;
        if (lower)
            cross_add = CROSS_W'({wij_reg, 1'b0});
        else if (diag)
            cross_add = CROSS_W'(wii_reg);
        else
            cross_add = '0;
        first_sum  = {1'b0, first_reg} + (FIRST_W+1)'(wi_reg);
        second_sum = {1'b0, second_reg} + (SECOND_W+1)'(wii_reg);
        cross_sum  = {1'b0, cross_reg} + {1'b0, cross_add};
    end

    // numerator and denominator magnitudes
    always_comb
    begin
        cw    = (PW+1)'(cross_reg) << WEIGHT_FRAC_BITS;
        sw    = (PW+1)'(second_reg) << WEIGHT_FRAC_BITS;
        sqx   = {1'b0, sq_reg};
        ndiff = (cw >= sqx) ? cw - sqx : sqx - cw;
        ddiff = (sw >= sqx) ? sw - sqx : sqx - sw;
        f_lo  = first_reg[HALF_W-1:0];
        f_hi  = first_reg[FIRST_W-1:HALF_W];
    end

    // one restoring division step
    always_comb
    begin
        rem_sh  = {rem_reg, nsh_reg[NB-1]};
        rem_sub = rem_sh - {1'b0, dd_reg};
    end

    always_comb
    begin
        neg  = nneg_reg ^ dneg_reg;
        qsat = ov_reg || q_reg[COEF_W-1];
        if (den_reg == '0)
        begin
            coef = (num_reg == '0) ? COEF_ONE : COEF_ERR;
            stat = (num_reg == '0) ? ST_DEGEN : ST_DIV0;
        end
        else
        begin
            stat = ST_OK;
            if (qsat)
                coef = neg ? COEF_MIN : COEF_MAX;
            else
                coef = neg ? COEF_W'(-q_reg) : q_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_ACCEPT;
            out_valid_reg <= 1'b0;
            cross_reg     <= '0;
            first_reg     <= '0;
            second_reg    <= '0;
        end
        else
        begin
            step_reg <= step_next;
            if (ctl.op == OP_OUT && !out_busy)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            case (ctl.op)
                OP_ACC:
                begin
                    if (entry_ok)
                    begin
                        first_reg  <= first_sum[FIRST_W] ? '1 : first_sum[FIRST_W-1:0];
                        second_reg <= second_sum[SECOND_W] ? '1 :
                                      second_sum[SECOND_W-1:0];
                        cross_reg  <= cross_sum[CROSS_W] ? '1 : cross_sum[CROSS_W-1:0];
                    end
                end
                OP_OUT:
                begin
                    if (!out_busy)
                    begin
                        cross_reg     <= '0;
                        first_reg     <= '0;
                        second_reg    <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            OP_ACCEPT:
            begin
                if (s_axis_tvalid)
                begin
                    row_reg  <= s_axis_tdata[IDX_W-1:0];
                    col_reg  <= s_axis_tdata[2*IDX_W-1:IDX_W];
                    w_reg    <= s_axis_tdata[2*IDX_W+WEIGHT_W-1:2*IDX_W];
                    last_reg <= s_axis_tlast;
                end
            end
            OP_MUL1:
            begin
                ii_reg <= row_reg * row_reg;
                ij_reg <= row_reg * col_reg;
                wi_reg <= w_reg * row_reg;
            end
            OP_MUL2:
            begin
                wii_reg <= w_reg * ii_reg;
                wij_reg <= w_reg * ij_reg;
            end
            OP_SQ_LL:
                prod_reg <= f_lo * f_lo;
            OP_SQ_HL:
            begin
                sq_reg   <= PW'(prod_reg);
                prod_reg <= f_hi * f_lo;
            end
            OP_SQ_MID:
            begin
                sq_reg   <= sq_reg + (PW'(prod_reg) << (HALF_W + 1));
                prod_reg <= f_hi * f_hi;
            end
            OP_SQ_HH:
                sq_reg <= sq_reg + (PW'(prod_reg) << (2 * HALF_W));
            OP_DIFF:
            begin
                num_reg  <= ndiff[PW-1:0];
                den_reg  <= ddiff[PW-1:0];
                nneg_reg <= cw < sqx;
                dneg_reg <= sw < sqx;
            end
            OP_PREP:
            begin
                nsh_reg <= (NB'(num_reg) << QFRAC) + NB'(den_reg);
                dd_reg  <= {den_reg, 1'b0};
                rem_reg <= '0;
                q_reg   <= '0;
                ov_reg  <= 1'b0;
                cnt_reg <= CNT_W'(NB - 1);
            end
            OP_DIV:
            begin
                nsh_reg <= nsh_reg << 1;
                ov_reg  <= ov_reg | q_reg[COEF_W-1];
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (!rem_sub[PW+1])
                begin
                    rem_reg <= rem_sub[PW:0];
                    q_reg   <= {q_reg[COEF_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[PW:0];
                    q_reg   <= {q_reg[COEF_W-2:0], 1'b0};
                end
            end
            OP_OUT:
            begin
                if (!out_busy)
                    out_data_reg <= OUT_W'({stat, coef});
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = 1'b1;

endmodule
